### design/ils_pkg.sv
// Shared constants and types for the indexed list store.
package ils_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [DATA_W-1:0] NO_VALUE = {DATA_W{1'b1}};

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

### design/indexed_list_store.sv
// Indexed list store: append, remove with close-up, read and clear over one slot RAM.
// Each accepted item goes to EXEC, where append, clear, failed requests and removal
// of the last element end; a valid read then passes RDW, other valid removes SHIFT
// (one RAM read/write step per element moved down). busy drops in the strobe cycle,
// so the next item may start then. The receiver cannot stall the result strobe.
// Synchronous active-low reset empties the list; slot contents are left as they are.
module indexed_list_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_req_type,
  input  logic [ils_pkg::ADDR_W-1:0] in_position,
  input  logic signed [31:0]         in_new_value,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic signed [31:0]         out_read_value,
  output logic [ils_pkg::CNT_W-1:0]  out_count,
  output logic                       out_is_empty
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_RDW   = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [ils_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]                 op_r;
  logic [ils_pkg::ADDR_W-1:0] pos_r;
  logic [ils_pkg::DATA_W-1:0] val_r;
  logic [ils_pkg::ADDR_W-1:0] idx_r, idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [ils_pkg::DATA_W-1:0] out_rd_r, out_rd_nxt;

  ils_pkg::ram_wr_t           wr;
  logic [ils_pkg::ADDR_W-1:0] raddr;
  logic [ils_pkg::DATA_W-1:0] rdata;

  logic                       accept;
  logic [ils_pkg::CNT_W-1:0]  pos_ext, idx_ext;

  ils_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept  = start && (state_r == ST_IDLE);
  assign pos_ext = {1'b0, pos_r};
  assign idx_ext = {1'b0, idx_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    wr.we         = 1'b0;
    wr.addr       = idx_r;
    wr.data       = rdata;
    raddr         = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_rd_nxt = ils_pkg::NO_VALUE;
        unique case (op_r)
          ils_pkg::OP_APPEND: begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = (cnt_r != ils_pkg::CNT_FULL);
            if (cnt_r != ils_pkg::CNT_FULL) begin
              wr.we   = 1'b1;
              wr.addr = cnt_r[ils_pkg::ADDR_W-1:0];
              wr.data = val_r;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          ils_pkg::OP_CLEAR: begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b1;
            cnt_nxt       = '0;
          end
          ils_pkg::OP_READ: begin
            raddr = pos_r;
            if (pos_ext < cnt_r) begin
              state_nxt = ST_RDW;
            end else begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              out_ok_nxt    = 1'b0;
            end
          end
          ils_pkg::OP_REMOVE: begin
            idx_nxt = pos_r;
            raddr   = pos_r + 1'b1;
            if (pos_ext + 1'b1 < cnt_r) begin
              // later elements exist: start moving them down
              state_nxt = ST_SHIFT;
            end else begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              out_ok_nxt    = (pos_ext < cnt_r);
              if (pos_ext < cnt_r) begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RDW: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_rd_nxt    = rdata;
      end
      ST_SHIFT: begin
        // rdata holds slot idx+1, issued last cycle
        wr.we   = 1'b1;
        wr.addr = idx_r;
        wr.data = rdata;
        idx_nxt = idx_r + 1'b1;
        raddr   = idx_r + 2'd2;
        if (idx_ext + 2'd2 >= cnt_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_rd_nxt    = ils_pkg::NO_VALUE;
          cnt_nxt       = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_req_type;
      pos_r <= in_position;
      val_r <= in_new_value;
    end
    idx_r    <= idx_nxt;
    out_ok_r <= out_ok_nxt;
    out_rd_r <= out_rd_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_count      = cnt_r;
  assign out_is_empty   = (cnt_r == '0);

endmodule

### design/ils_ram.sv
// Slot storage: one write port, one read port with registered data.
module ils_ram (
  input  logic                      clk,
  input  ils_pkg::ram_wr_t          wr,
  input  logic [ils_pkg::ADDR_W-1:0] raddr,
  output logic [ils_pkg::DATA_W-1:0] rdata
);

  logic [ils_pkg::DATA_W-1:0] mem_r [ils_pkg::CAPACITY];
  logic [ils_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/sv/ils_result_checker.sv
// Result checker for the indexed list store: tracks accepted items and compares every result.
module ils_result_checker
  import ils_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [ADDR_W-1:0]        in_position,
  input  logic signed [DATA_W-1:0] in_new_value,
  input  logic                     out_valid,
  input  logic                     out_ok,
  input  logic signed [DATA_W-1:0] out_read_value,
  input  logic [CNT_W-1:0]         out_count,
  input  logic                     out_is_empty,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
  } list_reply_t;

  logic signed [DATA_W-1:0] slots [CAPACITY];
  int unsigned              held;
  list_reply_t              replies_due [$];
  list_reply_t              due;

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
  end

  // Applies one request to the shadow list and returns the reply it should produce.
  function automatic list_reply_t apply_request(input logic [1:0] op,
                                                input logic [ADDR_W-1:0] pos,
                                                input logic signed [DATA_W-1:0] val);
    list_reply_t r;
    int unsigned i;
    r.ok         = 1'b0;
    r.read_value = NO_VALUE;
    case (op)
      OP_APPEND: begin
        if (held < CAPACITY) begin
          slots[held] = val;
          held++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < held) begin
          // later elements close up the gap
          for (i = pos; i + 1 < held; i++)
            slots[i] = slots[i + 1];
          held--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos < held) begin
          r.read_value = slots[pos];
          r.ok         = 1'b1;
        end
      end
      default: begin
        held = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count    = CNT_W'(held);
    r.is_empty = (held == 0);
    return r;
  endfunction

  task automatic report(input string field, input logic [DATA_W-1:0] exp_v,
                        input logic [DATA_W-1:0] act_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      replies_due.delete();
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item waiting, expected none, got ok=%b value=%h count=%0d",
                   $time, out_ok, out_read_value, out_count);
        end else begin
          due = replies_due.pop_front();
          if (out_ok !== due.ok)
            report("ok", DATA_W'(due.ok), DATA_W'(out_ok));
          if (out_read_value !== due.read_value)
            report("read_value", due.read_value, out_read_value);
          if (out_count !== due.count)
            report("count", DATA_W'(due.count), DATA_W'(out_count));
          if (out_is_empty !== due.is_empty)
            report("is_empty", DATA_W'(due.is_empty), DATA_W'(out_is_empty));
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_request(in_req_type, in_position, in_new_value));
    end
    pending = replies_due.size();
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the indexed list store: clock, reset, item stimulus and verdict.
module tb_top;
  import ils_pkg::*;

  localparam int NUM_RANDOM     = 1575;
  localparam int QUIET_TAIL     = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 24;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_req_type;
  logic [ADDR_W-1:0]        in_position;
  logic signed [DATA_W-1:0] in_new_value;
  logic                     out_valid;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]         out_count;
  logic                     out_is_empty;

  int fail_count;
  int pending;
  int idle_cycles;
  int occupancy;
  bit allow_gaps;

  indexed_list_store dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty)
  );

  ils_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: reset, any accepted item or result restarts the count.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Presents one item, holds it until accepted, then maybe idles for a burst.
  task automatic issue(input logic [1:0] op, input logic [ADDR_W-1:0] pos,
                       input logic [DATA_W-1:0] val);
    start        <= 1'b1;
    in_req_type  <= op;
    in_position  <= pos;
    in_new_value <= val;
    do @(posedge clk); while (busy);
    case (op)
      OP_APPEND: if (occupancy < CAPACITY) occupancy++;
      OP_REMOVE: if (pos < occupancy) occupancy--;
      OP_CLEAR:  occupancy = 0;
      default:   ;
    endcase
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  initial begin
    int          trend;
    int          roll;
    int          ap_lim;
    int          rm_lim;
    int          rd_lim;
    logic [1:0]  op;
    logic [3:0]  pos;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = OP_READ;
    in_position  = '0;
    in_new_value = '0;
    occupancy    = 0;
    allow_gaps   = 1'b1;
    trend        = 2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-list failures, fill to capacity, full refusal, boundary indexes
    issue(OP_READ, 4'd0, pick_value());
    issue(OP_REMOVE, 4'd0, pick_value());
    issue(OP_CLEAR, 4'd15, pick_value());
    issue(OP_APPEND, 4'd0, 32'h8000_0000);
    issue(OP_APPEND, 4'd15, 32'h7FFF_FFFF);
    issue(OP_APPEND, 4'd0, 32'hFFFF_FFFF);
    issue(OP_APPEND, 4'd0, 32'h0000_0000);
    for (int k = 0; k < 12; k++)
      issue(OP_APPEND, 4'(k), $urandom);
    issue(OP_APPEND, 4'd0, 32'h5A5A_A5A5);   // list full, refused
    issue(OP_READ, 4'd15, 32'h0);
    issue(OP_READ, 4'd0, 32'h0);
    issue(OP_REMOVE, 4'd0, 32'h0);
    issue(OP_REMOVE, 4'd15, 32'h0);          // count is 15 now, index out of range
    issue(OP_CLEAR, 4'd0, 32'h0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0)
        trend = $urandom_range(0, 2);
      allow_gaps = (n < NUM_RANDOM - QUIET_TAIL);
      case (trend)
        0:       begin ap_lim = 60; rm_lim = 75; rd_lim = 98; end  // filling up
        1:       begin ap_lim = 20; rm_lim = 70; rd_lim = 98; end  // draining
        default: begin ap_lim = 35; rm_lim = 65; rd_lim = 95; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ap_lim)      op = OP_APPEND;
      else if (roll < rm_lim) op = OP_REMOVE;
      else if (roll < rd_lim) op = OP_READ;
      else                    op = OP_CLEAR;
      // mostly valid indexes, some out of range
      if (occupancy > 0 && $urandom_range(0, 4) != 0)
        pos = 4'($urandom_range(0, occupancy - 1));
      else
        pos = 4'($urandom_range(0, 15));
      issue(op, pos, pick_value());
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
